// ===== design/tgp_pkg.sv =====
`default_nettype none

package tgp_pkg;

   // command codes of the request channel
   localparam logic [1:0] CMD_BEGIN  = 2'd0;
   localparam logic [1:0] CMD_APPEND = 2'd1;
   localparam logic [1:0] CMD_QUERY  = 2'd2;

   // segment kinds of the response channel
   localparam logic OP_MATCH  = 1'b0;
   localparam logic OP_INTRON = 1'b1;

   // field widths
   localparam int CMD_W      = 2;
   localparam int COORD_W    = 32;
   localparam int OFFSET_W   = 31;
   localparam int LEN_W      = 16;
   localparam int SEG_W      = 32;
   localparam int POS_W      = 33;
   localparam int SPAN_W     = 32;
   localparam int SPAN_ACC_W = 34;

   // controller to datapath
   typedef struct packed {
      logic do_begin;
      logic do_append;
      logic do_query;
      logic walk_step;
      logic emit_init;
      logic emit_gap;
      logic emit_match;
      logic emit_empty;
   } tgp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic walk_done;
      logic busy;
      logic blk_none;
      logic blk_one;
      logic out_free;
   } tgp_status_type;

endpackage

`default_nettype wire

// ===== design/tgp_if.sv =====
`default_nettype none

// request channel
interface tgp_req_if import tgp_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [CMD_W-1:0]    cmd;
   logic                minus_strand;
   logic [COORD_W-1:0]  exon_start;
   logic [COORD_W-1:0]  exon_end;
   logic [OFFSET_W-1:0] tx_offset;
   logic [LEN_W-1:0]    read_length;

   modport source (output valid, cmd, minus_strand, exon_start, exon_end, tx_offset,
                   read_length, input ready);
   modport sink   (input valid, cmd, minus_strand, exon_start, exon_end, tx_offset,
                   read_length, output ready);
endinterface

// response channel
interface tgp_rsp_if import tgp_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              valid_res;
   logic              seg_op;
   logic [SEG_W-1:0]  seg_length;
   logic [POS_W-1:0]  genomic_pos;
   logic [SPAN_W-1:0] total_span;
   logic              last;

   modport source (output valid, valid_res, seg_op, seg_length, genomic_pos, total_span,
                   last, input ready);
   modport sink   (input valid, valid_res, seg_op, seg_length, genomic_pos, total_span,
                   last, output ready);
endinterface

`default_nettype wire

// ===== design/transcript_to_genome_projector.sv =====
`default_nettype none

// Projects a read given in transcript coordinates onto the genome. A begin command
// opens a transcript and sets its strand, append commands add exons as zero-based
// [start,end) pairs to a table of MAX_EXONS entries, and a query returns the read as
// match and intron segments in ascending genomic order, ending with a result flagged
// last that carries the total reference span. For a query the exon table is walked
// one entry per cycle through a single read port, followed by a four-stage block
// pipeline that sorts each block into place. Results then leave at one per cycle
// through the response register while the receiver is ready, 2 * blocks - 1 of them,
// or a single invalid result when nothing projects. A new request is taken once the
// last result of the query is loaded.
module transcript_to_genome_projector
   import tgp_pkg::*;
#(
   parameter int MAX_EXONS = 32
) (
   input  logic      clock,
   input  logic      reset,
   tgp_req_if.sink   req,
   tgp_rsp_if.source rsp
);

   tgp_cmd_type    command;
   tgp_status_type status;

   // sequencer
   tgp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_cmd   (req.cmd),
      .req_ready (req.ready),
      .status    (status),
      .command   (command)
   );

   // exon table, walk pipeline, block row and response register
   tgp_dp #(
      .MAX_EXONS (MAX_EXONS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .command          (command),
      .status           (status),
      .req_minus_strand (req.minus_strand),
      .req_exon_start   (req.exon_start),
      .req_exon_end     (req.exon_end),
      .req_tx_offset    (req.tx_offset),
      .req_read_length  (req.read_length),
      .rsp_valid        (rsp.valid),
      .rsp_ready        (rsp.ready),
      .rsp_valid_res    (rsp.valid_res),
      .rsp_seg_op       (rsp.seg_op),
      .rsp_seg_length   (rsp.seg_length),
      .rsp_genomic_pos  (rsp.genomic_pos),
      .rsp_total_span   (rsp.total_span),
      .rsp_last         (rsp.last)
   );

endmodule

`default_nettype wire

// ===== design/tgp_ctrl.sv =====
`default_nettype none

module tgp_ctrl
   import tgp_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic [CMD_W-1:0] req_cmd,
   output logic             req_ready,
   input  tgp_status_type   status,
   output tgp_cmd_type      command
);

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_WALK  = 6'b000010,
      S_DRAIN = 6'b000100,
      S_MATCH = 6'b001000,
      S_GAP   = 6'b010000,
      S_EMPTY = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      command   = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               unique case (req_cmd)
                  CMD_BEGIN:  command.do_begin  = 1'b1;
                  CMD_APPEND: command.do_append = 1'b1;
                  CMD_QUERY: begin
                     command.do_query = 1'b1;
                     state_in         = S_WALK;
                  end
                  default: ;
               endcase
            end
         end
         S_WALK: begin
            if (status.walk_done) begin
               state_in = S_DRAIN;
            end else begin
               command.walk_step = 1'b1;
            end
         end
         S_DRAIN: begin
            if (!status.busy) begin
               if (status.blk_none) begin
                  state_in = S_EMPTY;
               end else begin
                  command.emit_init = 1'b1;
                  state_in          = S_MATCH;
               end
            end
         end
         S_MATCH: begin
            if (status.out_free) begin
               command.emit_match = 1'b1;
               state_in           = status.blk_one ? S_IDLE : S_GAP;
            end
         end
         S_GAP: begin
            if (status.out_free) begin
               command.emit_gap = 1'b1;
               state_in         = S_MATCH;
            end
         end
         S_EMPTY: begin
            if (status.out_free) begin
               command.emit_empty = 1'b1;
               state_in           = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/tgp_dp.sv =====
`default_nettype none

module tgp_dp
   import tgp_pkg::*;
#(
   parameter int MAX_EXONS = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  tgp_cmd_type         command,
   output tgp_status_type      status,
   input  logic                req_minus_strand,
   input  logic [COORD_W-1:0]  req_exon_start,
   input  logic [COORD_W-1:0]  req_exon_end,
   input  logic [OFFSET_W-1:0] req_tx_offset,
   input  logic [LEN_W-1:0]    req_read_length,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_valid_res,
   output logic                rsp_seg_op,
   output logic [SEG_W-1:0]    rsp_seg_length,
   output logic [POS_W-1:0]    rsp_genomic_pos,
   output logic [SPAN_W-1:0]   rsp_total_span,
   output logic                rsp_last
);

   localparam int AW = $clog2(MAX_EXONS);
   localparam int CW = $clog2(MAX_EXONS + 1);

   // transcript state
   logic [COORD_W-1:0] start_mem [MAX_EXONS];
   logic [COORD_W-1:0] end_mem   [MAX_EXONS];
   logic [CW-1:0]      count_ff;
   logic               strand_ff;

   // walk and pipeline
   logic [CW-1:0]       idx_ff;
   logic [CW-1:0]       rev_idx;
   logic [AW-1:0]       rd_addr;
   logic                rd_v_ff;
   logic [COORD_W-1:0]  rd_start_ff, rd_end_ff;
   logic                a_v_ff;
   logic [COORD_W-1:0]  a_start_ff, a_end_ff, a_elen_ff;
   logic [COORD_W-1:0]  a_elen_in;
   logic [OFFSET_W-1:0] skip_ff;
   logic [LEN_W-1:0]    rem_ff;
   logic [COORD_W:0]    skip_diff;
   logic [COORD_W-1:0]  avail;
   logic [COORD_W:0]    rem_diff;
   logic                past, short_read;
   logic [LEN_W-1:0]    take;
   logic                b_v_ff;
   logic [COORD_W-1:0]  b_start_ff, b_end_ff;
   logic [OFFSET_W-1:0] b_off_ff;
   logic [LEN_W-1:0]    b_take_ff;
   logic                c_v_ff;
   logic [COORD_W-1:0]  c_bs_ff, c_bs_in;
   logic [LEN_W-1:0]    c_len_ff;

   // sorted block row
   logic [COORD_W-1:0]   cell_start_ff [MAX_EXONS];
   logic [LEN_W-1:0]     cell_len_ff   [MAX_EXONS];
   logic [COORD_W-1:0]   cell_start_in [MAX_EXONS];
   logic [LEN_W-1:0]     cell_len_in   [MAX_EXONS];
   logic [MAX_EXONS-1:0] sel, cell_we;
   logic [CW-1:0]        nblk_ff;

   // result formation
   logic [POS_W-1:0]      first_pos_ff;
   logic [COORD_W:0]      last_end_ff;
   logic [SPAN_ACC_W-1:0] span_ff;
   logic [COORD_W:0]      head_start, gap_wide, last_end_in;
   logic [SPAN_ACC_W-1:0] span_gap, span_match;
   logic [SPAN_W-1:0]     span_sat;
   logic                  out_free;
   logic                  rsp_valid_ff, rsp_valid_res_ff, rsp_seg_op_ff, rsp_last_ff;
   logic [SEG_W-1:0]      rsp_seg_length_ff;
   logic [POS_W-1:0]      rsp_genomic_pos_ff;
   logic [SPAN_W-1:0]     rsp_total_span_ff;

   // begin and append
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         strand_ff <= 1'b0;
      end else if (command.do_begin) begin
         count_ff  <= '0;
         strand_ff <= req_minus_strand;
      end else if (command.do_append && (count_ff < CW'(MAX_EXONS))) begin
         count_ff <= count_ff + CW'(1);
      end
   end

   // exon table
   always_ff @(posedge clock) begin
      if (command.do_append && (count_ff < CW'(MAX_EXONS))) begin
         start_mem[count_ff[AW-1:0]] <= req_exon_start;
         end_mem[count_ff[AW-1:0]]   <= req_exon_end;
      end
      if (command.walk_step) begin
         rd_start_ff <= start_mem[rd_addr];
         rd_end_ff   <= end_mem[rd_addr];
      end
   end

   // walk index, reversed on the minus strand
   assign rev_idx = count_ff - idx_ff - CW'(1);
   assign rd_addr = strand_ff ? rev_idx[AW-1:0] : idx_ff[AW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else if (command.do_query) begin
         idx_ff <= '0;
      end else if (command.walk_step) begin
         idx_ff <= idx_ff + CW'(1);
      end
   end

   // stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_v_ff <= 1'b0;
         a_v_ff  <= 1'b0;
         b_v_ff  <= 1'b0;
         c_v_ff  <= 1'b0;
      end else begin
         rd_v_ff <= command.walk_step;
         a_v_ff  <= rd_v_ff;
         b_v_ff  <= a_v_ff && (rem_ff != '0) && !past;
         c_v_ff  <= b_v_ff;
      end
   end

   // exon length, reversed exons count as empty
   assign a_elen_in = (rd_end_ff > rd_start_ff) ? (rd_end_ff - rd_start_ff) : '0;

   always_ff @(posedge clock) begin
      a_start_ff <= rd_start_ff;
      a_end_ff   <= rd_end_ff;
      a_elen_ff  <= a_elen_in;
   end

   // skip offset and remaining length, the walk recurrence
   assign skip_diff  = {2'b0, skip_ff} - {1'b0, a_elen_ff};
   assign past       = !skip_diff[COORD_W];
   assign avail      = a_elen_ff - {1'b0, skip_ff};
   assign rem_diff   = {{(COORD_W + 1 - LEN_W){1'b0}}, rem_ff} - {1'b0, avail};
   assign short_read = rem_diff[COORD_W];
   assign take       = short_read ? rem_ff : avail[LEN_W-1:0];

   always_ff @(posedge clock) begin
      if (command.do_query) begin
         skip_ff <= req_tx_offset;
         rem_ff  <= req_read_length;
      end else if (a_v_ff && (rem_ff != '0)) begin
         if (past) begin
            skip_ff <= skip_diff[OFFSET_W-1:0];
         end else begin
            skip_ff <= '0;
            rem_ff  <= short_read ? '0 : rem_diff[LEN_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      b_start_ff <= a_start_ff;
      b_end_ff   <= a_end_ff;
      b_off_ff   <= skip_ff;
      b_take_ff  <= take;
   end

   // genomic start of the block
   assign c_bs_in = strand_ff ?
                    (b_end_ff - {1'b0, b_off_ff} - {{(COORD_W - LEN_W){1'b0}}, b_take_ff}) :
                    (b_start_ff + {1'b0, b_off_ff});

   always_ff @(posedge clock) begin
      c_bs_ff  <= c_bs_in;
      c_len_ff <= b_take_ff;
   end

   // insertion row: cells above the new start move up one place, head shifts out on emit
   for (genvar p = 0; p < MAX_EXONS; p++) begin : g_cell
      logic [COORD_W-1:0] up_start, down_start;
      logic [LEN_W-1:0]   up_len, down_len;
      logic               up_sel;

      assign sel[p] = ((CW'(p) < nblk_ff) && (cell_start_ff[p] > c_bs_ff)) ||
                      (nblk_ff == CW'(p));

      if (p == 0) begin : g_head
         assign up_start = c_bs_ff;
         assign up_len   = c_len_ff;
         assign up_sel   = 1'b0;
      end else begin : g_body
         assign up_start = cell_start_ff[p-1];
         assign up_len   = cell_len_ff[p-1];
         assign up_sel   = sel[p-1];
      end

      if (p == MAX_EXONS - 1) begin : g_tail
         assign down_start = cell_start_ff[p];
         assign down_len   = cell_len_ff[p];
      end else begin : g_inner
         assign down_start = cell_start_ff[p+1];
         assign down_len   = cell_len_ff[p+1];
      end

      assign cell_we[p] = (c_v_ff && sel[p]) || command.emit_match;

      always_comb begin
         if (command.emit_match) begin
            cell_start_in[p] = down_start;
            cell_len_in[p]   = down_len;
         end else if (up_sel) begin
            cell_start_in[p] = up_start;
            cell_len_in[p]   = up_len;
         end else begin
            cell_start_in[p] = c_bs_ff;
            cell_len_in[p]   = c_len_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int p = 0; p < MAX_EXONS; p++) begin
         if (cell_we[p]) begin
            cell_start_ff[p] <= cell_start_in[p];
            cell_len_ff[p]   <= cell_len_in[p];
         end
      end
   end

   // block count
   always_ff @(posedge clock) begin
      if (reset) begin
         nblk_ff <= '0;
      end else if (command.do_query) begin
         nblk_ff <= '0;
      end else if (c_v_ff) begin
         nblk_ff <= nblk_ff + CW'(1);
      end else if (command.emit_match) begin
         nblk_ff <= nblk_ff - CW'(1);
      end
   end

   // gap, span and end of the previous block
   assign head_start  = {1'b0, cell_start_ff[0]};
   assign gap_wide    = (head_start > last_end_ff) ? (head_start - last_end_ff) : '0;
   assign span_gap    = span_ff + {1'b0, gap_wide};
   assign span_match  = span_ff + {{(SPAN_ACC_W - LEN_W){1'b0}}, cell_len_ff[0]};
   assign span_sat    = (span_match[SPAN_ACC_W-1:SPAN_W] != '0) ? '1 : span_match[SPAN_W-1:0];
   assign last_end_in = head_start + {{(COORD_W + 1 - LEN_W){1'b0}}, cell_len_ff[0]};

   always_ff @(posedge clock) begin
      if (command.emit_init) begin
         first_pos_ff <= head_start + POS_W'(1);
         span_ff      <= '0;
      end else if (command.emit_gap) begin
         span_ff <= span_gap;
      end else if (command.emit_match) begin
         span_ff     <= span_match;
         last_end_ff <= last_end_in;
      end
   end

   // response register
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (command.emit_gap || command.emit_match || command.emit_empty) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (command.emit_match) begin
         rsp_valid_res_ff   <= 1'b1;
         rsp_seg_op_ff      <= OP_MATCH;
         rsp_seg_length_ff  <= {{(SEG_W - LEN_W){1'b0}}, cell_len_ff[0]};
         rsp_genomic_pos_ff <= first_pos_ff;
         rsp_total_span_ff  <= (nblk_ff == CW'(1)) ? span_sat : '0;
         rsp_last_ff        <= (nblk_ff == CW'(1));
      end else if (command.emit_gap) begin
         rsp_valid_res_ff   <= 1'b1;
         rsp_seg_op_ff      <= OP_INTRON;
         rsp_seg_length_ff  <= gap_wide[SEG_W-1:0];
         rsp_genomic_pos_ff <= first_pos_ff;
         rsp_total_span_ff  <= '0;
         rsp_last_ff        <= 1'b0;
      end else if (command.emit_empty) begin
         rsp_valid_res_ff   <= 1'b0;
         rsp_seg_op_ff      <= OP_MATCH;
         rsp_seg_length_ff  <= '0;
         rsp_genomic_pos_ff <= '0;
         rsp_total_span_ff  <= '0;
         rsp_last_ff        <= 1'b1;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_valid_res   = rsp_valid_res_ff;
   assign rsp_seg_op      = rsp_seg_op_ff;
   assign rsp_seg_length  = rsp_seg_length_ff;
   assign rsp_genomic_pos = rsp_genomic_pos_ff;
   assign rsp_total_span  = rsp_total_span_ff;
   assign rsp_last        = rsp_last_ff;

   // status
   assign status.walk_done = (idx_ff == count_ff);
   assign status.busy      = rd_v_ff || a_v_ff || b_v_ff || c_v_ff;
   assign status.blk_none  = (nblk_ff == '0);
   assign status.blk_one   = (nblk_ff == CW'(1));
   assign status.out_free  = out_free;

`ifndef SYNTHESIS
   // an invalid result always closes its query
   a_invalid_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_valid_res_ff |-> rsp_last_ff)
      else $error("invalid result without last");

   // at most one block per exon
   a_blk_bound: assert property (@(posedge clock) disable iff (reset)
      nblk_ff <= count_ff)
      else $error("more blocks than exons");

   // the row stays sorted by genomic start
   a_row_sorted: assert property (@(posedge clock) disable iff (reset)
      nblk_ff >= CW'(2) |-> cell_start_ff[0] <= cell_start_ff[1])
      else $error("block row out of order");

   // a result is only loaded into a free response register
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      command.emit_gap || command.emit_match || command.emit_empty |-> out_free)
      else $error("result overwrites pending response");

   // the walk never reads past the table fill
   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      command.walk_step |-> idx_ff != count_ff)
      else $error("walk beyond exon count");
`endif

endmodule

`default_nettype wire

// ===== sim/tgp_projection_checker.sv =====
module tgp_projection_checker
   import tgp_pkg::*;
#(
   parameter int MAX_EXONS = 32
) (
   input  logic clock,
   input  logic reset,
   tgp_req_if   req,
   tgp_rsp_if   rsp,
   output int   mismatch_count,
   output int   segments_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   // one response transfer as the block should produce it
   typedef struct packed {
      logic              valid_res;
      logic              seg_op;
      logic [SEG_W-1:0]  seg_length;
      logic [POS_W-1:0]  genomic_pos;
      logic [SPAN_W-1:0] total_span;
      logic              last;
   } segment_type;

   // mirror of the exon table and strand
   logic [COORD_W-1:0] exon_starts [MAX_EXONS];
   logic [COORD_W-1:0] exon_ends   [MAX_EXONS];
   int                 exons_loaded;
   logic               on_minus;

   segment_type        expected_segments [$];
   segment_type        want;
   int                 results_seen;

   task automatic report_mismatch(input string what);
      if (mismatch_count < 60)
         $display("%0t ns: response %0d: %s", $time, results_seen, what);
      mismatch_count++;
   endtask

   // cut the read into blocks along the exons, sort them by genomic start and
   // queue the match and intron segments that the query must return
   function automatic void project_read(input logic [OFFSET_W-1:0] offset,
                                        input logic [LEN_W-1:0]    length);
      logic [COORD_W-1:0] blk_start [MAX_EXONS];
      logic [COORD_W-1:0] blk_len   [MAX_EXONS];
      segment_type        segs      [2*MAX_EXONS];
      segment_type        seg;
      longint unsigned    pos, cursor, span, last_end, gap;
      logic [31:0]        remaining, es, ee, elen, off, avail, take, bs;
      logic [POS_W-1:0]   first_pos;
      int                 nblk, idx, j, k;
      pos       = 64'(offset);
      cursor    = 0;
      span      = 0;
      remaining = 32'(length);
      nblk      = 0;
      k         = 0;

      // walk in transcript order, reversed on the minus strand
      for (int i = 0; i < exons_loaded && remaining != 0; i++) begin
         idx  = on_minus ? exons_loaded - 1 - i : i;
         es   = exon_starts[idx];
         ee   = exon_ends[idx];
         elen = (ee > es) ? ee - es : 32'd0;
         if (pos >= cursor + elen) begin
            cursor += elen;
            continue;
         end
         off   = (pos > cursor) ? 32'(pos - cursor) : 32'd0;
         avail = elen - off;
         take  = (remaining < avail) ? remaining : avail;
         bs    = on_minus ? ee - off - take : es + off;
         // stable insertion, equal starts keep walk order
         j = nblk;
         while (j > 0 && blk_start[j-1] > bs) begin
            blk_start[j] = blk_start[j-1];
            blk_len[j]   = blk_len[j-1];
            j--;
         end
         blk_start[j] = bs;
         blk_len[j]   = take;
         nblk++;
         remaining -= take;
         pos       += take;
         cursor    += elen;
      end

      // nothing projected: single invalid result
      if (nblk == 0) begin
         seg      = '0;
         seg.last = 1'b1;
         expected_segments.insert(expected_segments.size(), seg);
         return;
      end

      first_pos = POS_W'(blk_start[0]) + 1'b1;
      for (int i = 0; i < nblk; i++) begin
         seg             = '0;
         seg.valid_res   = 1'b1;
         seg.genomic_pos = first_pos;
         if (i > 0) begin
            last_end       = 64'(blk_start[i-1]) + 64'(blk_len[i-1]);
            gap            = (64'(blk_start[i]) > last_end) ? 64'(blk_start[i]) - last_end : 0;
            span          += gap;
            seg.seg_op     = OP_INTRON;
            seg.seg_length = SEG_W'(gap);
            segs[k]        = seg;
            k++;
         end
         span          += blk_len[i];
         seg.seg_op     = OP_MATCH;
         seg.seg_length = blk_len[i];
         segs[k]        = seg;
         k++;
      end
      // span saturates, carried on the final segment only
      segs[k-1].total_span = (span > 64'hFFFF_FFFF) ? {SPAN_W{1'b1}} : SPAN_W'(span);
      segs[k-1].last       = 1'b1;
      for (int i = 0; i < k; i++)
         expected_segments.insert(expected_segments.size(), segs[i]);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         exons_loaded   = 0;
         on_minus       = 1'b0;
         results_seen   = 0;
         mismatch_count = 0;
         expected_segments.delete();
      end else begin
         // response transfer against the oldest expectation
         if (rsp.valid && rsp.ready) begin
            if (expected_segments.size() == 0) begin
               report_mismatch("response with no segment expected");
            end else begin
               want = expected_segments.pop_front();
               if (rsp.valid_res !== want.valid_res)
                  report_mismatch($sformatf("valid_res %0d, expected %0d",
                                            rsp.valid_res, want.valid_res));
               if (rsp.seg_op !== want.seg_op)
                  report_mismatch($sformatf("seg_op %0d, expected %0d",
                                            rsp.seg_op, want.seg_op));
               if (rsp.seg_length !== want.seg_length)
                  report_mismatch($sformatf("seg_length %0d, expected %0d",
                                            rsp.seg_length, want.seg_length));
               if (rsp.genomic_pos !== want.genomic_pos)
                  report_mismatch($sformatf("genomic_pos %0d, expected %0d",
                                            rsp.genomic_pos, want.genomic_pos));
               if (rsp.total_span !== want.total_span)
                  report_mismatch($sformatf("total_span %0d, expected %0d",
                                            rsp.total_span, want.total_span));
               if (rsp.last !== want.last)
                  report_mismatch($sformatf("last %0d, expected %0d", rsp.last, want.last));
            end
            results_seen++;
         end

         // request transfer updates the table or predicts a query
         if (req.valid && req.ready) begin
            case (req.cmd)
               CMD_BEGIN: begin
                  exons_loaded = 0;
                  on_minus     = req.minus_strand;
               end
               CMD_APPEND: begin
                  if (exons_loaded < MAX_EXONS) begin
                     exon_starts[exons_loaded] = req.exon_start;
                     exon_ends[exons_loaded]   = req.exon_end;
                     exons_loaded++;
                  end
               end
               CMD_QUERY: begin
                  project_read(req.tx_offset, req.read_length);
               end
               default: begin
               end
            endcase
         end
      end
      segments_pending = expected_segments.size();
   end

endmodule

// ===== sim/tb_transcript_to_genome_projector.sv =====
module tb_transcript_to_genome_projector
   import tgp_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int         EXON_SLOTS   = 32;
   localparam logic [1:0] CMD_UNUSED   = 2'd3;
   localparam int         HOLD_CYCLES  = 300;
   localparam int         IDLE_LIMIT   = 2000;
   localparam int         RANDOM_ITEMS = 185;
   localparam int         DRAIN_CYCLES = 120;

   logic clock;
   logic reset;
   int   mismatch_count;
   int   segments_pending;
   int   items_sent;
   bit   no_gaps;
   bit   hold_request;

   tgp_req_if req_ch ();
   tgp_rsp_if rsp_ch ();

   transcript_to_genome_projector #(
      .MAX_EXONS(EXON_SLOTS)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req  (req_ch),
      .rsp  (rsp_ch)
   );

   tgp_projection_checker #(
      .MAX_EXONS(EXON_SLOTS)
   ) projection_check (
      .clock           (clock),
      .reset           (reset),
      .req             (req_ch),
      .rsp             (rsp_ch),
      .mismatch_count  (mismatch_count),
      .segments_pending(segments_pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // one request transfer after a random gap
   task automatic send(input logic [1:0] cmd, input logic minus, input logic [31:0] xs,
                       input logic [31:0] xe, input logic [30:0] offset,
                       input logic [15:0] length);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.cmd          <= cmd;
      req_ch.minus_strand <= minus;
      req_ch.exon_start   <= xs;
      req_ch.exon_end     <= xe;
      req_ch.tx_offset    <= offset;
      req_ch.read_length  <= length;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
      items_sent++;
   endtask

   // unused fields carry random bits
   task automatic open_transcript(input logic minus);
      send(CMD_BEGIN, minus, $urandom, $urandom, 31'($urandom), 16'($urandom));
   endtask

   task automatic add_exon(input logic [31:0] xs, input logic [31:0] xe);
      send(CMD_APPEND, 1'($urandom), xs, xe, 31'($urandom), 16'($urandom));
   endtask

   task automatic project_query(input logic [30:0] offset, input logic [15:0] length);
      send(CMD_QUERY, 1'($urandom), $urandom, $urandom, offset, length);
   endtask

   task automatic send_unused_cmd();
      send(CMD_UNUSED, 1'($urandom), $urandom, $urandom, 31'($urandom), 16'($urandom));
   endtask

   // mostly ascending exons with random content, some empty, reversed or stray
   task automatic random_transcript(input int n_exons, input int n_queries, input bit tiny);
      longint unsigned base, tx_len, top_off;
      logic [31:0]     xs, xe;
      logic [30:0]     offset;
      logic [15:0]     length;
      int              exon_len, pick;
      open_transcript(1'($urandom));
      pick = $urandom_range(0, 3);
      if (pick == 0)
         base = 64'hFFF0_0000 + $urandom_range(0, 32'h000F_0000);
      else if (pick == 1)
         base = $urandom;
      else
         base = $urandom_range(0, 1 << 20);
      tx_len = 0;
      for (int i = 0; i < n_exons; i++) begin
         base    += $urandom_range(0, 400);
         exon_len = tiny ? $urandom_range(1, 12) : $urandom_range(1, 300);
         xs       = 32'(base);
         xe       = 32'(base + exon_len);
         pick     = $urandom_range(0, 19);
         if (pick == 0) begin
            xs = $urandom;
            xe = $urandom;
         end else if (pick == 1) begin
            xe = xs;
         end else if (pick == 2) begin
            {xs, xe} = {xe, xs};
         end
         base += exon_len;
         if (i < EXON_SLOTS && xe > xs)
            tx_len += xe - xs;
         add_exon(xs, xe);
      end
      top_off = (tx_len > 64'h7FFF_FFFF) ? 64'h7FFF_FFFF : tx_len;
      for (int q = 0; q < n_queries; q++) begin
         if ($urandom_range(0, 11) == 0)
            send_unused_cmd();
         pick = $urandom_range(0, 15);
         if (pick == 0)
            offset = 31'($urandom);
         else if (pick == 1)
            offset = 31'(top_off);
         else
            offset = 31'($urandom_range(0, 32'(top_off)));
         pick = $urandom_range(0, 15);
         if (pick == 0)
            length = '0;
         else if (pick == 1)
            length = 16'hFFFF;
         else if (pick == 2)
            length = 16'($urandom);
         else
            length = 16'($urandom_range(1, tiny ? 100 : 400));
         project_query(offset, length);
      end
   endtask

   // response side, with one long hold-off on request
   initial begin : response_sink
      int stall;
      rsp_ch.ready = 1'b0;
      wait (!reset);
      @(negedge clock);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            stall        = HOLD_CYCLES;
         end else begin
            stall = no_gaps ? 0 : $urandom_range(0, 4);
         end
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         @(negedge clock);
      end
   end

   // ends the run when no transfer happens for too long
   initial begin : watchdog
      int idle;
      idle = 0;
      while (idle < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle = 0;
         else
            idle++;
      end
      $display("tb_transcript_to_genome_projector: FAIL");
      $finish;
   end

   initial begin : stimulus
      int  random_start;
      bit  held;
      reset               = 1'b1;
      no_gaps             = 1'b0;
      hold_request        = 1'b0;
      held                = 1'b0;
      items_sent          = 0;
      req_ch.valid        = 1'b0;
      req_ch.cmd          = CMD_BEGIN;
      req_ch.minus_strand = 1'b0;
      req_ch.exon_start   = '0;
      req_ch.exon_end     = '0;
      req_ch.tx_offset    = '0;
      req_ch.read_length  = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // query on an empty table
      project_query(31'd0, 16'd5);

      // plus strand: zero length, exon crossing, truncation, offset at the end
      open_transcript(1'b0);
      add_exon(32'd100, 32'd200);
      add_exon(32'd300, 32'd350);
      add_exon(32'd1000, 32'd1100);
      project_query(31'd0, 16'd0);
      project_query(31'd50, 16'd100);
      project_query(31'd0, 16'hFFFF);
      project_query(31'd250, 16'd1);
      send_unused_cmd();

      // minus strand with a reversed exon in the middle
      open_transcript(1'b1);
      add_exon(32'd0, 32'd40);
      add_exon(32'd100, 32'd150);
      add_exon(32'd300, 32'd250);
      add_exon(32'd400, 32'd430);
      project_query(31'd10, 16'd100);
      project_query(31'd0, 16'hFFFF);

      // widest exon, largest offset
      open_transcript(1'b0);
      add_exon(32'd0, 32'hFFFF_FFFF);
      project_query(31'h7FFF_FFFF, 16'hFFFF);

      // overlapping blocks and span saturation
      open_transcript(1'b0);
      add_exon(32'd0, 32'h10);
      add_exon(32'hFFFF_FF00, 32'hFFFF_FFFF);
      add_exon(32'hFFFF_FF00, 32'hFFFF_FFFF);
      project_query(31'd0, 16'h200);

      // random part: first overfill the table and walk all of it
      random_start = items_sent;
      random_transcript(34, 2, 1'b1);
      project_query(31'd0, 16'hFFFF);
      while (items_sent - random_start < RANDOM_ITEMS) begin
         no_gaps = ($urandom_range(0, 3) == 0);
         if (!held && items_sent - random_start > 100) begin
            // receiver stalls while queries keep coming
            held         = 1'b1;
            no_gaps      = 1'b1;
            hold_request = 1'b1;
            random_transcript(3, 8, 1'b0);
         end else if ($urandom_range(0, 7) == 0) begin
            random_transcript($urandom_range(20, 34), $urandom_range(1, 4),
                              1'($urandom_range(0, 1)));
         end else if ($urandom_range(0, 15) == 0) begin
            random_transcript(0, $urandom_range(1, 2), 1'b0);
         end else begin
            random_transcript($urandom_range(1, 6), $urandom_range(1, 5), 1'b0);
         end
      end
      req_ch.valid <= 1'b0;

      // drain and let stray responses show up
      wait (segments_pending == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("tb_transcript_to_genome_projector: PASS");
      else
         $display("tb_transcript_to_genome_projector: FAIL");
      $finish;
   end

endmodule
